### sv/vvsd_pkg.sv
// ----------------------------------------------------------------------------
// vvsd_pkg
// Item types and fixed widths shared by the variance and deviation block.
// ----------------------------------------------------------------------------
package vvsd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 33;
    localparam int SUMSQ_W   = 55;
    localparam int VAR_W     = 47;
    localparam int STD_W     = 24;
    localparam int CNT_OUT_W = 9;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int NUM_W     = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        logic [VAR_W-1:0]     var_value;
        logic [STD_W-1:0]     std_value;
        logic [CNT_OUT_W-1:0] elem_count;
        logic                 too_long;
    } out_item_t;

endpackage

### sv/vector_variance_std_dev.sv
// ----------------------------------------------------------------------------
// vector_variance_std_dev
// Population variance and standard deviation of one streamed sample vector.
// ----------------------------------------------------------------------------
// Samples arrive on the s_ channel, one item per signed sample, with last set
// on the final element of a vector. Each accepted sample passes through S_SQ
// and S_ACC: the shared 32x32 multiplier squares it and the sum updates, then
// the sum of squares and the count update. A sample beyond MAX_LEN is dropped
// and flags too_long. On the last item the same multiplier forms n*S2 - S1^2
// and n^2 in S_NS_LO, S_NS_HI, S_A1SQ and S_NN, then a restoring divider and
// the square root run in turn to give the variance and the deviation.
// One result item per vector leaves on the m_ channel from an output
// register; the next vector is accepted while that result waits. If the
// receiver stalls and a second result is ready, the block holds it and
// takes no input until the output register frees.
// Reset clears the accumulators, the count, too_long and m_valid, and idles.
// ----------------------------------------------------------------------------
module vector_variance_std_dev
    import vvsd_pkg::*;
#(
    parameter int MAX_LEN = 256
)(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int DEN_W = 2 * CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_NS_LO = 4'd3;
    localparam logic [3:0] S_NS_HI = 4'd4;
    localparam logic [3:0] S_A1SQ  = 4'd5;
    localparam logic [3:0] S_NN    = 4'd6;
    localparam logic [3:0] S_DEN   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic                last_reg, last_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUMSQ_W-1:0]  sumsq_reg, sumsq_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [NUM_W-1:0]    acc_reg, acc_next;
    logic [VAR_W-1:0]    vres_reg, vres_next;
    out_item_t           out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic                s_accept;
    logic                out_free;
    logic                out_load;
    logic [SAMPLE_W-1:0] x_mag;
    logic [SUM_W-1:0]    a1;
    logic [NUM_W-1:0]    a1_cross;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_quot;
    logic                sqrt_start, sqrt_done;
    logic [STD_W-1:0]    sqrt_root;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign x_mag    = x_reg[SAMPLE_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign a1       = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    // cross term 2*h*l*2^32 of (h*2^32 + l)^2, taken modulo 2^64
    assign a1_cross = a1[SUM_W-1] ? {a1[MUL_W-2:0], {(MUL_W+1){1'b0}}} : '0;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ: begin
                mul_a = MUL_W'(x_mag);
                mul_b = MUL_W'(x_mag);
            end
            S_NS_LO: begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = sumsq_reg[MUL_W-1:0];
            end
            S_NS_HI: begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = MUL_W'(sumsq_reg[SUMSQ_W-1:MUL_W]);
            end
            S_A1SQ: begin
                mul_a = a1[MUL_W-1:0];
                mul_b = a1[MUL_W-1:0];
            end
            S_NN: begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = MUL_W'(cnt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        acc_next     = acc_reg;
        vres_next    = vres_reg;
        out_next     = out_reg;
        out_load     = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    x_next    = s_data.sample;
                    last_next = s_data.last;
                    if (cnt_reg < CNT_MAX) begin
                        state_next = S_SQ;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_data.last) begin
                            state_next = S_NS_LO;
                        end
                    end
                end
            end
            S_SQ: begin
                sum_next   = sum_reg + {{(SUM_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
                state_next = S_ACC;
            end
            S_ACC: begin
                sumsq_next = sumsq_reg + SUMSQ_W'(mul_p[2*SAMPLE_W-1:0]);
                cnt_next   = cnt_reg + 1'b1;
                state_next = last_reg ? S_NS_LO : S_IDLE;
            end
            S_NS_LO: begin
                state_next = S_NS_HI;
            end
            S_NS_HI: begin
                acc_next   = mul_p - a1_cross;
                state_next = S_A1SQ;
            end
            S_A1SQ: begin
                acc_next   = acc_reg + {mul_p[MUL_W-1:0], {MUL_W{1'b0}}};
                state_next = S_NN;
            end
            S_NN: begin
                acc_next   = acc_reg - mul_p;
                state_next = S_DEN;
            end
            S_DEN: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    vres_next  = div_quot[VAR_W-1:0];
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.var_value  = vres_reg;
                    out_next.std_value  = sqrt_root;
                    out_next.elem_count = CNT_OUT_W'(cnt_reg);
                    out_next.too_long   = ovf_reg;
                    sum_next            = '0;
                    sumsq_next          = '0;
                    cnt_next            = '0;
                    ovf_next            = 1'b0;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            sumsq_reg   <= sumsq_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        vres_reg <= vres_next;
        out_reg  <= out_next;
    end

    vvsd_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    vvsd_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_reg),
        .den     (mul_p[DEN_W-1:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    vvsd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quot[VAR_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // element count never passes the vector limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("element count beyond limit");

    // state is cleared once a result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (cnt_reg == '0 && sum_reg == '0 && sumsq_reg == '0 && !ovf_reg))
        else $error("accumulators not cleared after result");

    // root is the floor of the square root of the variance
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((2*STD_W)'(m_data.std_value) * (2*STD_W)'(m_data.std_value)
                     <= (2*STD_W)'(m_data.var_value)))
        else $error("root too large");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((2*STD_W+2)'(m_data.std_value) + 1'b1)
                     * ((2*STD_W+2)'(m_data.std_value) + 1'b1)
                     > (2*STD_W+2)'(m_data.var_value)))
        else $error("root too small");

endmodule

### sv/vvsd_mul.sv
// ----------------------------------------------------------------------------
// vvsd_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module vvsd_mul
    import vvsd_pkg::*;
(
    input  logic              aclk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### sv/vvsd_div.sv
// ----------------------------------------------------------------------------
// vvsd_div
// Restoring divider, one quotient bit per cycle, done pulses after NUM_W steps.
// ----------------------------------------------------------------------------
module vvsd_div
    import vvsd_pkg::*;
#(
    parameter int DEN_W = 18
)(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### sv/vvsd_sqrt.sv
// ----------------------------------------------------------------------------
// vvsd_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vvsd_sqrt
    import vvsd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [VAR_W-1:0] radicand,
    output logic             done,
    output logic [STD_W-1:0] root
);

    localparam int SQ_W   = 2 * STD_W;
    localparam int STEP_W = $clog2(STD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SQ_W-1:0]   rem_reg, rem_next;
    logic [SQ_W-1:0]   res_reg, res_next;
    logic [SQ_W-1:0]   bit_reg, bit_next;

    logic [SQ_W-1:0]   trial;
    logic              fits;

    assign trial = res_reg + bit_reg;
    assign fits  = rem_reg >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(STD_W);
            rem_next  = SQ_W'(radicand);
            res_next  = '0;
            bit_next  = {2'b01, {(SQ_W-2){1'b0}}};
        end else if (busy_reg) begin
            rem_next  = fits ? rem_reg - trial : rem_reg;
            res_next  = fits ? (res_reg >> 1) + bit_reg : res_reg >> 1;
            bit_next  = bit_reg >> 2;
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[STD_W-1:0];

endmodule
